### design/pdbf_pkg.sv
package pdbf_pkg;

  // Frame store geometry
  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);

  // Field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BADDR_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  // Clip arithmetic: box coordinates plus headroom for the signed sums
  localparam int unsigned CLIP_W = 14;
  // Pixel index: row * line width + column, below 2^(2*DIM_W)
  localparam int unsigned PIX_W  = 2 * DIM_W;

  localparam logic [PIX_W-1:0] STORE_LIMIT = PIX_W'(STORE_BYTES);

  // Register reset values
  localparam logic [DIM_W-1:0] ROW_PIXELS_RST   = DIM_W'(320);
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(200);

  // Nibble masks
  localparam logic [BYTE_W-1:0] NIB_LO_MASK = 8'h0f;
  localparam logic [BYTE_W-1:0] NIB_HI_MASK = 8'hf0;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_PIXELS   = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_PACKED_MODE  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] row_pixels;
    logic [DIM_W-1:0] image_height;
    logic             packed_mode;
  } cfg_t;

  // One-port store access: read or write at a single address
  typedef struct packed {
    logic                we;
    logic                re;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   wdata;
  } mem_req_t;

endpackage

### design/pdbf_if.sv
// Command item channel
interface pdbf_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [pdbf_pkg::CMD_W-1:0]          command;
  logic signed [pdbf_pkg::COORD_W-1:0] box_x;
  logic signed [pdbf_pkg::COORD_W-1:0] box_y;
  logic signed [pdbf_pkg::COORD_W-1:0] box_width;
  logic signed [pdbf_pkg::COORD_W-1:0] box_height;
  logic [pdbf_pkg::BYTE_W-1:0]         fill_color;
  logic [pdbf_pkg::BADDR_W-1:0]        byte_address;
  logic [pdbf_pkg::BYTE_W-1:0]         write_byte;

  modport source (
    output valid, command, box_x, box_y, box_width, box_height,
           fill_color, byte_address, write_byte,
    input  ready
  );
  modport sink (
    input  valid, command, box_x, box_y, box_width, box_height,
           fill_color, byte_address, write_byte,
    output ready
  );
endinterface

// Result item channel
interface pdbf_res_if;
  logic                        valid;
  logic                        ready;
  logic [pdbf_pkg::BYTE_W-1:0] read_byte;
  logic                        done_res;

  modport source (output valid, read_byte, done_res, input ready);
  modport sink   (input  valid, read_byte, done_res, output ready);
endinterface

// Register write channel
interface pdbf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pdbf_pkg::CFG_IDX_W-1:0]  index;
  logic [pdbf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input  valid, index, data, output ready);
endinterface

### design/pdbf_store.sv
module pdbf_store (
  input  logic                          clk_i,
  input  pdbf_pkg::mem_req_t            req_i,
  output logic [pdbf_pkg::BYTE_W-1:0]   rdata_o
);
  import pdbf_pkg::*;

  logic [BYTE_W-1:0] mem [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/pdbf_cfg_regs.sv
module pdbf_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  pdbf_cfg_if.sink       cfg_i,
  output pdbf_pkg::cfg_t cfg_o
);
  import pdbf_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_pixels   <= ROW_PIXELS_RST;
      cfg_q.image_height <= IMAGE_HEIGHT_RST;
      cfg_q.packed_mode  <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_ROW_PIXELS:   cfg_q.row_pixels   <= cfg_i.data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_i.data[DIM_W-1:0];
        CFG_PACKED_MODE:  cfg_q.packed_mode  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pdbf_engine.sv
module pdbf_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pdbf_cmd_if.sink                    cmd_i,
  pdbf_res_if.source                  res_o,
  input  pdbf_pkg::cfg_t              cfg_i,
  output pdbf_pkg::mem_req_t          mem_req_o,
  input  logic [pdbf_pkg::BYTE_W-1:0] mem_rdata_i
);
  import pdbf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_RD_DATA,
    S_WR,
    S_CLIP_LO,
    S_CLIP_HI,
    S_CHECK,
    S_ROW,
    S_PIX,
    S_RMW,
    S_DONE
  } state_e;

  state_e                    state_q;
  logic signed [CLIP_W-1:0]  x_q, y_q, w_q, h_q;
  logic [BYTE_W-1:0]         color_q;
  logic [PIX_W-1:0]          addr_q;
  logic [BYTE_W-1:0]         wbyte_q;
  logic [PIX_W-1:0]          base_q, i_q, end_q;
  logic [DIM_W-1:0]          rows_q;
  logic                      xpar_q, ypar_q;
  logic [BYTE_W-1:0]         rd_q;
  logic                      res_valid_q;
  logic [BYTE_W-1:0]         res_byte_q;

  logic signed [CLIP_W-1:0]  lw_s, ih_s, x_end, y_end;
  logic [2*DIM_W-1:0]        row_prod;
  logic [PIX_W-1:0]          pix_addr, i_inc;
  logic                      pix_ok, addr_ok, span_edge;
  logic [3:0]                lo_nib, hi_nib, dith_nib;
  logic [BYTE_W-1:0]         pair_byte, merge_byte;

  // Clip helpers
  assign lw_s  = signed'(CLIP_W'(cfg_i.row_pixels));
  assign ih_s  = signed'(CLIP_W'(cfg_i.image_height));
  assign x_end = x_q + w_q;
  assign y_end = y_q + h_q;

  // First pixel of the top row
  assign row_prod = y_q[DIM_W-1:0] * cfg_i.row_pixels;

  // Span walk
  assign i_inc     = i_q + PIX_W'(1);
  assign pix_addr  = cfg_i.packed_mode ? (i_q >> 1) : i_q;
  assign pix_ok    = pix_addr < STORE_LIMIT;
  assign addr_ok   = addr_q < STORE_LIMIT;
  assign span_edge = i_q[0] || (i_inc == end_q);

  // Colour nibbles: whole bytes follow row parity, edge nibbles x xor y
  assign lo_nib     = color_q[3:0];
  assign hi_nib     = color_q[7:4];
  assign dith_nib   = (xpar_q ^ ypar_q) ? hi_nib : lo_nib;
  assign pair_byte  = ypar_q ? {lo_nib, hi_nib} : {hi_nib, lo_nib};
  assign merge_byte = i_q[0] ? ((mem_rdata_i & NIB_LO_MASK) | {dith_nib, 4'b0000})
                             : ((mem_rdata_i & NIB_HI_MASK) | {4'b0000, dith_nib});

  // Store access for the current step
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = pix_addr[STORE_AW-1:0];
    mem_req_o.wdata = color_q;
    case (state_q)
      S_RD: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = addr_q[STORE_AW-1:0];
      end
      S_WR: begin
        mem_req_o.we    = addr_ok;
        mem_req_o.addr  = addr_q[STORE_AW-1:0];
        mem_req_o.wdata = wbyte_q;
      end
      S_PIX: begin
        if (i_q != end_q) begin
          if (!cfg_i.packed_mode) begin
            mem_req_o.we = pix_ok;
          end else if (span_edge) begin
            mem_req_o.re = 1'b1;
          end else begin
            mem_req_o.we    = pix_ok;
            mem_req_o.wdata = pair_byte;
          end
        end
      end
      S_RMW: begin
        mem_req_o.we    = pix_ok;
        mem_req_o.wdata = merge_byte;
      end
      default: ;
    endcase
  end

  assign cmd_i.ready    = (state_q == S_IDLE);
  assign res_o.valid    = res_valid_q;
  assign res_o.read_byte = res_byte_q;
  assign res_o.done_res = 1'b1;

  // Command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      // result taken; a new one posted this cycle is set in S_DONE instead
      if (res_valid_q && res_o.ready && state_q != S_DONE) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_i.valid) begin
            x_q     <= CLIP_W'(cmd_i.box_x);
            y_q     <= CLIP_W'(cmd_i.box_y);
            w_q     <= CLIP_W'(cmd_i.box_width);
            h_q     <= CLIP_W'(cmd_i.box_height);
            color_q <= cmd_i.fill_color;
            addr_q  <= PIX_W'(cmd_i.byte_address);
            wbyte_q <= cmd_i.write_byte;
            rd_q    <= '0;
            case (cmd_e'(cmd_i.command))
              CMD_FILL:  state_q <= S_CLIP_LO;
              CMD_READ:  state_q <= S_RD;
              CMD_WRITE: state_q <= S_WR;
              default:   state_q <= S_DONE;
            endcase
          end
        end
        S_RD:      state_q <= S_RD_DATA;
        S_RD_DATA: begin
          rd_q    <= addr_ok ? mem_rdata_i : '0;
          state_q <= S_DONE;
        end
        S_WR:      state_q <= S_DONE;
        // Negative corner: shrink the box and pin it to the edge
        S_CLIP_LO: begin
          if (x_q < 0) begin
            w_q <= w_q + x_q;
            x_q <= '0;
          end
          if (y_q < 0) begin
            h_q <= h_q + y_q;
            y_q <= '0;
          end
          state_q <= S_CLIP_HI;
        end
        // Far edges: trim to the image
        S_CLIP_HI: begin
          if (x_end >= lw_s) begin
            w_q <= lw_s - x_q;
          end
          if (y_end >= ih_s) begin
            h_q <= ih_s - y_q;
          end
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (w_q <= 0 || h_q <= 0) begin
            state_q <= S_DONE;
          end else begin
            base_q  <= PIX_W'(row_prod) + PIX_W'(x_q[DIM_W-1:0]);
            rows_q  <= h_q[DIM_W-1:0];
            ypar_q  <= y_q[0];
            state_q <= S_ROW;
          end
        end
        S_ROW: begin
          i_q     <= base_q;
          end_q   <= base_q + PIX_W'(w_q[DIM_W-1:0]);
          xpar_q  <= x_q[0];
          state_q <= S_PIX;
        end
        S_PIX: begin
          if (i_q == end_q) begin
            if (rows_q == DIM_W'(1)) begin
              state_q <= S_DONE;
            end else begin
              rows_q  <= rows_q - DIM_W'(1);
              base_q  <= base_q + PIX_W'(cfg_i.row_pixels);
              ypar_q  <= ~ypar_q;
              state_q <= S_ROW;
            end
          end else if (!cfg_i.packed_mode) begin
            i_q <= i_inc;
          end else if (span_edge) begin
            state_q <= S_RMW;
          end else begin
            i_q <= i_q + PIX_W'(2);
          end
        end
        S_RMW: begin
          i_q     <= i_inc;
          xpar_q  <= ~xpar_q;
          state_q <= S_PIX;
        end
        S_DONE: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q <= 1'b1;
            res_byte_q  <= rd_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### design/packed_dither_box_fill.sv
// Read byte: S_RD, S_RD_DATA, then S_DONE posts the result; write byte: S_WR, S_DONE.
// Fill: clipping and setup in S_CLIP_LO, S_CLIP_HI and S_CHECK, then per clipped row
// S_ROW and S_PIX (byte mode: a byte per pixel; packed mode: a pair byte per pixel
// pair, a read and an S_RMW merge for each odd leading or trailing nibble), then S_DONE.
// One item at a time; next taken the cycle after posting, which waits on a held result.
// Reset: registers to width 320, height 200, byte mode; store contents undefined.
module packed_dither_box_fill (
  input  logic       clk_i,
  input  logic       rst_ni,
  pdbf_cfg_if.sink   cfg_i,
  pdbf_cmd_if.sink   cmd_i,
  pdbf_res_if.source res_o
);
  import pdbf_pkg::*;

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  pdbf_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pdbf_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .cfg_i       (cfg),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  pdbf_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // One item in flight: ready drops after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready |=> !cmd_i.ready)
    else $error("command taken while another is in flight");

  // The store is only touched while a command is being worked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we || mem_req.re) |-> !cmd_i.ready)
    else $error("store access while idle");

  // Single port: never a read and a write together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("store read and write in one cycle");

endmodule

### sim/packed_dither_box_fill_tb.sv
`timescale 1ns / 100ps

module packed_dither_box_fill_tb;
  import pdbf_pkg::*;

  // Command code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct {
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic signed [COORD_W-1:0] box_width;
    logic signed [COORD_W-1:0] box_height;
    logic [BYTE_W-1:0]         fill_color;
    logic [BADDR_W-1:0]        byte_address;
    logic [BYTE_W-1:0]         write_byte;
  } box_cmd_t;

  typedef struct {
    logic [BYTE_W-1:0] read_byte;
    logic              done_res;
  } done_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pdbf_cfg_if cfg_bus ();
  pdbf_cmd_if cmd_bus ();
  pdbf_res_if res_bus ();

  packed_dither_box_fill u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  // Predicted store contents and register copies
  bit [BYTE_W-1:0] store_image [STORE_BYTES];
  int unsigned     geo_width;
  int unsigned     geo_height;
  bit              geo_packed;

  done_item_t  pending_results[$];
  int unsigned mismatch_count;
  int unsigned cycles_run;
  int unsigned res_hold_req;
  bit          src_calm;
  bit          sink_calm;
  bit          cmd_up;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycles_run++;
    if (cycles_run == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Wait drawn per item; now and then switch between idling and back-to-back
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic bit [3:0] dither_nibble(bit [BYTE_W-1:0] col, int x, int y);
    return ((x ^ y) & 1) ? col[7:4] : col[3:0];
  endfunction

  // One-nibble read-modify-write; bytes beyond the store are dropped
  function automatic void set_nibble(int unsigned pix, bit [3:0] nib);
    int unsigned a;
    a = pix >> 1;
    if (a < STORE_BYTES) begin
      if (pix[0]) store_image[a][7:4] = nib;
      else store_image[a][3:0] = nib;
    end
  endfunction

  function automatic void paint_packed_row(int unsigned first, int count,
                                           bit [BYTE_W-1:0] col, int x, int y);
    int unsigned i;
    int unsigned stop;
    bit [BYTE_W-1:0] pair;
    // whole bytes follow row parity: even rows low nibble first
    pair = y[0] ? {col[3:0], col[7:4]} : col;
    i = first;
    stop = first + count;
    if (i[0]) begin
      set_nibble(i, dither_nibble(col, x, y));
      i++;
      x++;
    end
    while (i + 2 <= stop) begin
      if ((i >> 1) < STORE_BYTES) store_image[i >> 1] = pair;
      i += 2;
      x += 2;
    end
    if (i < stop) set_nibble(i, dither_nibble(col, x, y));
  endfunction

  function automatic void paint_box(int x, int y, int w, int h, bit [BYTE_W-1:0] col);
    int maxx;
    int maxy;
    int r;
    int c;
    int unsigned base;
    maxx = int'(geo_width) - 1;
    maxy = int'(geo_height) - 1;
    // clip to the image
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x + w > maxx) w = maxx - x + 1;
    if (y + h > maxy) h = maxy - y + 1;
    if (w <= 0 || h <= 0) return;
    for (r = 0; r < h; r++) begin
      base = (y + r) * geo_width + x;
      if (geo_packed) begin
        paint_packed_row(base, w, col, x, y + r);
      end else begin
        for (c = 0; c < w; c++)
          if (base + c < STORE_BYTES) store_image[base + c] = col;
      end
    end
  endfunction

  function automatic done_item_t apply_command(box_cmd_t it);
    done_item_t r;
    r.read_byte = '0;
    r.done_res  = 1'b1;
    case (it.command)
      CMD_FILL: begin
        paint_box(it.box_x, it.box_y, it.box_width, it.box_height, it.fill_color);
      end
      CMD_READ: begin
        r.read_byte = store_image[it.byte_address];
      end
      CMD_WRITE: begin
        store_image[it.byte_address] = it.write_byte;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    done_item_t want;
    int stall_left;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result item with none expected: read_byte %h done_res %b",
                   $time, res_bus.read_byte, res_bus.done_res);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (res_bus.read_byte !== want.read_byte) begin
            $display("%0t: read_byte expected %h actual %h",
                     $time, want.read_byte, res_bus.read_byte);
            mismatch_count++;
          end
          if (res_bus.done_res !== want.done_res) begin
            $display("%0t: done_res expected %b actual %b",
                     $time, want.done_res, res_bus.done_res);
            mismatch_count++;
          end
        end
        stall_left = draw_gap(sink_calm);
      end
      // long hold-off requested by a test
      if (res_hold_req != 0) begin
        stall_left = res_hold_req;
        res_hold_req = 0;
      end
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- command side

  task automatic send_item(box_cmd_t it);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      if (cmd_up) cmd_bus.valid <= 1'b0;
      cmd_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.command      <= it.command;
    cmd_bus.box_x        <= it.box_x;
    cmd_bus.box_y        <= it.box_y;
    cmd_bus.box_width    <= it.box_width;
    cmd_bus.box_height   <= it.box_height;
    cmd_bus.fill_color   <= it.fill_color;
    cmd_bus.byte_address <= it.byte_address;
    cmd_bus.write_byte   <= it.write_byte;
    cmd_up = 1'b1;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    pending_results.push_back(apply_command(it));
  endtask

  task automatic cmd_idle();
    if (cmd_up) cmd_bus.valid <= 1'b0;
    cmd_up = 1'b0;
  endtask

  // Stop offering, wait for every awaited result, then let the block settle
  task automatic wait_results_drained();
    cmd_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register writes only once the block is idle
  task automatic set_geometry(int unsigned lw, int unsigned ih, bit pm);
    wait_results_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_ROW_PIXELS;
    cfg_bus.data  <= CFG_DATA_W'(lw);
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.index <= CFG_IMAGE_HEIGHT;
    cfg_bus.data  <= CFG_DATA_W'(ih);
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.index <= CFG_PACKED_MODE;
    cfg_bus.data  <= CFG_DATA_W'(pm);
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    geo_width  = lw;
    geo_height = ih;
    geo_packed = pm;
  endtask

  // Every field random but the command, which is the unused code; callers override what matters
  function automatic box_cmd_t scrambled_item();
    box_cmd_t it;
    it.command      = CMD_UNUSED;
    it.box_x        = COORD_W'($urandom);
    it.box_y        = COORD_W'($urandom);
    it.box_width    = COORD_W'($urandom);
    it.box_height   = COORD_W'($urandom);
    it.fill_color   = BYTE_W'($urandom);
    it.byte_address = BADDR_W'($urandom);
    it.write_byte   = BYTE_W'($urandom);
    return it;
  endfunction

  task automatic send_fill(int x, int y, int w, int h, bit [BYTE_W-1:0] col);
    box_cmd_t it;
    it = scrambled_item();
    it.command    = CMD_FILL;
    it.box_x      = COORD_W'(x);
    it.box_y      = COORD_W'(y);
    it.box_width  = COORD_W'(w);
    it.box_height = COORD_W'(h);
    it.fill_color = col;
    send_item(it);
  endtask

  task automatic send_read(int unsigned addr);
    box_cmd_t it;
    it = scrambled_item();
    it.command      = CMD_READ;
    it.byte_address = BADDR_W'(addr);
    send_item(it);
  endtask

  task automatic send_write(int unsigned addr, bit [BYTE_W-1:0] data);
    box_cmd_t it;
    it = scrambled_item();
    it.command      = CMD_WRITE;
    it.byte_address = BADDR_W'(addr);
    it.write_byte   = data;
    send_item(it);
  endtask

  // Mostly boxes around the image and addresses inside it, the rest full range
  function automatic box_cmd_t random_command();
    box_cmd_t it;
    int unsigned span;
    int unsigned pick;
    it = scrambled_item();
    span = geo_width * geo_height;
    if (geo_packed) span = (span + 1) / 2;
    if (span > STORE_BYTES) span = STORE_BYTES;
    if (span == 0) span = 1;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.command = CMD_FILL;
      if ($urandom_range(0, 9) < 7) begin
        it.box_x      = COORD_W'(int'($urandom_range(0, geo_width + 7)) - 4);
        it.box_y      = COORD_W'(int'($urandom_range(0, geo_height + 7)) - 4);
        it.box_width  = COORD_W'(int'($urandom_range(0, 22)) - 2);
        it.box_height = COORD_W'(int'($urandom_range(0, 14)) - 2);
      end
    end else if (pick < 80) begin
      it.command = CMD_READ;
      if ($urandom_range(0, 9) < 6) it.byte_address = BADDR_W'($urandom_range(0, span - 1));
    end else if (pick < 95) begin
      it.command = CMD_WRITE;
      if ($urandom_range(0, 9) < 6) it.byte_address = BADDR_W'($urandom_range(0, span - 1));
    end
    return it;
  endfunction

  task automatic run_random(int unsigned lw, int unsigned ih, bit pm, int unsigned count);
    set_geometry(lw, ih, pm);
    repeat (count) send_item(random_command());
  endtask

  // ---------------------------------------------------------------- tests

  // Clipped fill under the reset geometry, before any register write
  task automatic test_reset_geometry();
    send_fill(310, 195, 2047, 2047, 8'hc3);
    send_read(195 * 320 + 310);
    send_read(199 * 320 + 319);
  endtask

  // One fill covering every store byte, so later reads and nibble updates see written data
  task automatic test_store_clear();
    set_geometry(1024, 64, 1'b0);
    send_fill(0, 0, 1024, 64, 8'h5a);
  endtask

  task automatic test_byte_clipping();
    box_cmd_t it;
    set_geometry(1024, 1024, 1'b0);
    send_fill(-1024, -1024, 1030, 1027, 8'hff);
    // last store row written, the row below falls past the store
    send_fill(1020, 63, 2047, 2, 8'h3c);
    send_fill(2047, 5, 4, -1024, 8'h00);
    send_read(16'hffff);
    send_read(1020);
    send_read(2 * 1024 + 5);
    send_write(16'hffff, 8'hff);
    send_read(16'hffff);
    it = scrambled_item();
    send_item(it);
  endtask

  // Odd leading nibble, whole pairs, even trailing nibble
  task automatic test_packed_dither();
    set_geometry(16, 8, 1'b1);
    send_fill(1, 1, 5, 3, 8'h96);
    send_fill(2, 4, 3, 2, 8'h1e);
    send_read(8);
    send_read(9);
    send_read(33);
    send_read(34);
  endtask

  // Packed rows of odd width straddle bytes
  task automatic test_odd_width();
    set_geometry(7, 5, 1'b1);
    send_fill(0, 0, 7, 5, 8'hc5);
    send_read(2);
    send_read(17);
  endtask

  // Zero width or height clips everything away
  task automatic test_degenerate_geometry();
    set_geometry(0, 5, 1'b0);
    send_fill(0, 0, 4, 4, 8'h11);
    set_geometry(5, 0, 1'b0);
    send_fill(0, 0, 4, 4, 8'h22);
    send_read(0);
  endtask

  task automatic test_random_geometries();
    run_random(32, 16, 1'b0, 250);
    run_random(32, 16, 1'b1, 300);
    run_random(17, 9, 1'b1, 150);
    run_random(1, 1, 1'b0, 60);
    run_random(1024, 2, 1'b1, 120);
    run_random(2, 1024, 1'b1, 120);
  endtask

  // Receiver holds off while items keep coming, then the sender waits for a full drain
  task automatic test_backpressure();
    set_geometry(64, 32, 1'b0);
    res_hold_req = LONG_HOLD;
    repeat (100) send_item(random_command());
    wait_results_drained();
    repeat (100) send_item(random_command());
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= CFG_ROW_PIXELS;
    cfg_bus.data         <= '0;
    cmd_bus.valid        <= 1'b0;
    cmd_bus.command      <= CMD_FILL;
    cmd_bus.box_x        <= '0;
    cmd_bus.box_y        <= '0;
    cmd_bus.box_width    <= '0;
    cmd_bus.box_height   <= '0;
    cmd_bus.fill_color   <= '0;
    cmd_bus.byte_address <= '0;
    cmd_bus.write_byte   <= '0;
    geo_width  = ROW_PIXELS_RST;
    geo_height = IMAGE_HEIGHT_RST;
    geo_packed = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_geometry();
    test_store_clear();
    test_byte_clipping();
    test_packed_dither();
    test_odd_width();
    test_degenerate_geometry();
    test_random_geometries();
    test_backpressure();

    wait_results_drained();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
design/pdbf_pkg.sv
design/pdbf_if.sv
design/pdbf_store.sv
design/pdbf_cfg_regs.sv
design/pdbf_engine.sv
design/packed_dither_box_fill.sv
sim/packed_dither_box_fill_tb.sv
